// ----- hw/rtl/pftpr_pkg.sv -----
// Package for the page frame table: request and result types, codes and sizes.
// No dependencies.
`timescale 1ns / 1ps
package pftpr_pkg;
  localparam int Frames = 16;
  localparam int FrameBits = 4;
  localparam int PageBits = 24;

  localparam logic [1:0] MODE_PIN   = 2'd0;
  localparam logic [1:0] MODE_UNPIN = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;
  localparam logic [1:0] MODE_FLUSH = 2'd3;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_DEALL = 2'd3;

  typedef struct packed {
    logic [1:0]          mode;
    logic [PageBits-1:0] page_id;
    logic                empty_page;
    logic                mark_dirty;
    logic                hate;
  } req_t;

  typedef struct packed {
    logic                 status;
    logic [FrameBits-1:0] frame;
    logic [1:0]           action;
    logic [PageBits-1:0]  io_page;
    logic                 last;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture request, clear scan state
    logic scan_page;  // examine frame idx for a page match / free frame
    logic scan_rec;   // examine recency slot idx for victim choice
    logic find_pos;   // examine recency slot idx for the move position
    logic shift;      // shift recency slot idx from idx-1
    logic commit;     // apply table update and place frame at the front
    logic [FrameBits-1:0] idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic pos_found;
    logic [FrameBits-1:0] pos;
  } sts_t;
endpackage

// ----- hw/rtl/pftpr_ctrl.sv -----
// Sequencer for the page frame table: steps the scans, the shift and the commit.
// Depends on pftpr_pkg.
`timescale 1ns / 1ps
module pftpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pftpr_pkg::sts_t   sts,
  output pftpr_pkg::cmd_t   cmd
);
  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_PAGE, S_REC, S_POS, S_SHIFT, S_COMMIT}
    state_t;
  state_t state_r, state_nxt;
  logic [pftpr_pkg::FrameBits-1:0] idx_r, idx_nxt;
  localparam logic [pftpr_pkg::FrameBits-1:0] LastIdx = pftpr_pkg::FrameBits'(pftpr_pkg::Frames-1);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    cmd = '0;
    cmd.idx = idx_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_PAGE;
          idx_nxt = '0;
        end
      end
      S_PAGE: begin
        cmd.scan_page = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LastIdx) begin
          idx_nxt = '0;
          state_nxt = S_REC;
        end
      end
      S_REC: begin
        cmd.scan_rec = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LastIdx) begin
          idx_nxt = '0;
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        cmd.find_pos = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LastIdx) begin
          state_nxt = S_SHIFT;
          idx_nxt = sts.pos;
        end
      end
      S_SHIFT: begin
        if (idx_r == '0) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.shift = 1'b1;
          idx_nxt = idx_r - 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
endmodule

// ----- hw/rtl/pftpr_dp.sv -----
// Datapath for the page frame table: frame table, recency list, scans, results.
// Depends on pftpr_pkg.
`timescale 1ns / 1ps
module pftpr_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  pftpr_pkg::req_t   req,
  input  pftpr_pkg::cmd_t   cmd,
  output pftpr_pkg::sts_t   sts,
  output logic              out_valid,
  output pftpr_pkg::res_t   out_res
);
  localparam int N = pftpr_pkg::Frames;
  localparam int FB = pftpr_pkg::FrameBits;
  localparam int PB = pftpr_pkg::PageBits;

  logic [PB-1:0] page_r [N];
  logic [N-1:0]  valid_r, dirty_r, loved_r, used_r;
  logic [7:0]    pin_r [N];
  logic [FB-1:0] order_r [N];

  pftpr_pkg::req_t req_r;
  logic          hit_r, free_found_r, hate_found_r, love_found_r, pos_found_r;
  logic [FB-1:0] hit_f_r, free_f_r, hate_f_r, love_f_r, pos_r;
  logic          second_r;
  pftpr_pkg::res_t pend_r;

  // Victim and target frame, valid once the scans are done.
  logic [FB-1:0] vict;
  logic          have_vict;
  logic [FB-1:0] tgt;
  logic          mv;
  always_comb begin
    have_vict = free_found_r | hate_found_r | love_found_r;
    vict = free_found_r ? free_f_r : (hate_found_r ? hate_f_r : love_f_r);
    tgt = hit_r ? hit_f_r : vict;
    mv = (req_r.mode == pftpr_pkg::MODE_PIN) &&
         (hit_r ? (pin_r[hit_f_r] != 8'hFF) : have_vict);
  end

  assign sts.hit = hit_r;
  assign sts.pos_found = pos_found_r;
  assign sts.pos = pos_found_r ? pos_r : FB'(N-1);

  logic [FB-1:0] slot_f;
  assign slot_f = order_r[cmd.idx];

  // Result of the commit step. A dirty victim is written back first and the
  // read (or the empty-page answer) is held for the following cycle.
  pftpr_pkg::res_t com_res, fill_res;
  logic            wb_need;
  always_comb begin
    fill_res.status = 1'b0;
    fill_res.frame = vict;
    fill_res.action = req_r.empty_page ? pftpr_pkg::ACT_NONE : pftpr_pkg::ACT_READ;
    fill_res.io_page = req_r.empty_page ? '0 : req_r.page_id;
    fill_res.last = 1'b1;
    com_res.status = 1'b1;
    com_res.frame = hit_r ? hit_f_r : '0;
    com_res.action = pftpr_pkg::ACT_NONE;
    com_res.io_page = '0;
    com_res.last = 1'b1;
    wb_need = 1'b0;
    case (req_r.mode)
      pftpr_pkg::MODE_PIN: begin
        if (hit_r) begin
          if (mv) com_res.status = 1'b0;
        end else if (have_vict) begin
          wb_need = valid_r[vict] && dirty_r[vict];
          if (wb_need) begin
            com_res.status = 1'b0;
            com_res.frame = vict;
            com_res.action = pftpr_pkg::ACT_WRITE;
            com_res.io_page = page_r[vict];
            com_res.last = 1'b0;
          end else begin
            com_res = fill_res;
          end
        end
      end
      pftpr_pkg::MODE_UNPIN: begin
        if (hit_r && pin_r[hit_f_r] != 8'd0) com_res.status = 1'b0;
      end
      pftpr_pkg::MODE_FREE: begin
        if (!hit_r || pin_r[hit_f_r] == 8'd0) begin
          com_res.status = 1'b0;
          com_res.action = pftpr_pkg::ACT_DEALL;
          com_res.io_page = req_r.page_id;
        end
      end
      default: begin
        if (hit_r) begin
          com_res.status = 1'b0;
          com_res.action = pftpr_pkg::ACT_WRITE;
          com_res.io_page = req_r.page_id;
        end
      end
    endcase
  end

  // Table, recency list, scan state and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0; dirty_r <= '0; loved_r <= '0; used_r <= '0;
      for (int i = 0; i < N; i++) pin_r[i] <= '0;
      out_valid <= 1'b0;
      second_r <= 1'b0;
      hit_r <= 1'b0; free_found_r <= 1'b0; hate_found_r <= 1'b0;
      love_found_r <= 1'b0; pos_found_r <= 1'b0;
    end else begin
      // Result strobe: the commit result, or the held second result.
      if (cmd.commit) begin
        out_valid <= 1'b1;
        out_res <= com_res;
        second_r <= wb_need;
        pend_r <= fill_res;
      end else begin
        out_valid <= second_r;
        second_r <= 1'b0;
        if (second_r) out_res <= pend_r;
      end
      if (cmd.load) begin
        req_r <= req;
        hit_r <= 1'b0; free_found_r <= 1'b0; hate_found_r <= 1'b0;
        love_found_r <= 1'b0; pos_found_r <= 1'b0;
      end
      // Associative search and lowest free frame.
      if (cmd.scan_page) begin
        if (valid_r[cmd.idx] && page_r[cmd.idx] == req_r.page_id && !hit_r) begin
          hit_r <= 1'b1; hit_f_r <= cmd.idx;
        end
        if (!valid_r[cmd.idx] && !free_found_r) begin
          free_found_r <= 1'b1; free_f_r <= cmd.idx;
        end
      end
      // Victim choice walks the list from the front.
      if (cmd.scan_rec && used_r[cmd.idx] && pin_r[slot_f] == 8'd0) begin
        if (!loved_r[slot_f]) begin
          if (!hate_found_r) begin
            hate_found_r <= 1'b1; hate_f_r <= slot_f;
          end
        end else begin
          love_found_r <= 1'b1; love_f_r <= slot_f;
        end
      end
      // Slot from which the target is removed.
      if (cmd.find_pos && !pos_found_r && (!used_r[cmd.idx] || order_r[cmd.idx] == tgt)) begin
        pos_found_r <= 1'b1; pos_r <= cmd.idx;
      end
      if (cmd.shift && mv) begin
        order_r[cmd.idx] <= order_r[cmd.idx - 1'b1];
        used_r[cmd.idx] <= used_r[cmd.idx - 1'b1];
      end
      // Apply the request to the table.
      if (cmd.commit) begin
        case (req_r.mode)
          pftpr_pkg::MODE_PIN: begin
            if (mv) begin
              order_r[0] <= tgt;
              used_r[0] <= 1'b1;
            end
            if (hit_r) begin
              if (mv) pin_r[hit_f_r] <= pin_r[hit_f_r] + 8'd1;
            end else if (have_vict) begin
              page_r[vict] <= req_r.page_id;
              valid_r[vict] <= 1'b1;
              dirty_r[vict] <= 1'b0;
              pin_r[vict] <= 8'd1;
            end
          end
          pftpr_pkg::MODE_UNPIN: begin
            if (hit_r && pin_r[hit_f_r] != 8'd0) begin
              pin_r[hit_f_r] <= pin_r[hit_f_r] - 8'd1;
              loved_r[hit_f_r] <= !req_r.hate;
              if (req_r.mark_dirty) dirty_r[hit_f_r] <= 1'b1;
            end
          end
          pftpr_pkg::MODE_FREE: begin
            if (hit_r && pin_r[hit_f_r] == 8'd0) begin
              valid_r[hit_f_r] <= 1'b0;
              dirty_r[hit_f_r] <= 1'b0;
              loved_r[hit_f_r] <= 1'b0;
            end
          end
          default: begin
            if (hit_r) dirty_r[hit_f_r] <= 1'b0;
          end
        endcase
      end
    end
  end
endmodule

// ----- hw/rtl/page_frame_table_pin_replace_top.sv -----
// Top level of the page frame table with love/hate replacement.
// Depends on pftpr_pkg, pftpr_ctrl and pftpr_dp.
`timescale 1ns / 1ps
// Usage: drive in_req and raise start while busy is low; the request is taken
// at that edge. The block searches its 16 frames for the page one frame per
// cycle, walks the recency list once to choose a victim and once more to find
// where the frame sits, shifts the list one slot per cycle and then updates
// the table. Results leave on out_res, one cycle each, marked by out_valid;
// last is set on the final result of a request.
// A pin miss with a dirty victim gives two results: the write-back, then the
// read, on consecutive cycles.
// The three scans over the 16 frames and the shift of up to 15 slots lie
// between the accepting edge and the last result; busy falls with the last
// result and a new request may follow at once.
// A synchronous active-low reset empties the table and the recency list.
// The receiver cannot stall: each result is valid for exactly one cycle.
module page_frame_table_pin_replace_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  pftpr_pkg::req_t in_req,
  output logic            out_valid,
  output pftpr_pkg::res_t out_res
);
  pftpr_pkg::cmd_t cmd;
  pftpr_pkg::sts_t sts;
  logic ctrl_busy, dp_valid, second;

  // The sequencer only sees a request that is actually accepted.
  pftpr_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .start(start && !busy), .busy(ctrl_busy),
                     .sts(sts), .cmd(cmd));
  pftpr_dp u_dp (.clk(clk), .rst_n(rst_n), .req(in_req), .cmd(cmd), .sts(sts),
                 .out_valid(dp_valid), .out_res(out_res));

  // Hold busy while a second result is still to come.
  assign second = dp_valid && !out_res.last;
  assign busy = ctrl_busy | second;
  assign out_valid = dp_valid;
endmodule

// ----- tb/page_frame_table_pin_replace_top_test.sv -----
// Testbench for the page frame table with love/hate replacement.
// Predicts every result from its own model of the frame table and checks them in order.
// Depends on pftpr_pkg and page_frame_table_pin_replace_top.
`timescale 1ns / 1ps
module page_frame_table_pin_replace_top_test;
  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  pftpr_pkg::req_t in_req;
  logic out_valid;
  pftpr_pkg::res_t out_res;

  page_frame_table_pin_replace_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  // Model copy of the frame table.
  logic [pftpr_pkg::PageBits-1:0] tbl_page [pftpr_pkg::Frames];
  logic tbl_valid [pftpr_pkg::Frames];
  logic tbl_dirty [pftpr_pkg::Frames];
  logic tbl_loved [pftpr_pkg::Frames];
  logic [7:0] tbl_pins [pftpr_pkg::Frames];
  logic [pftpr_pkg::FrameBits-1:0] mru_list [pftpr_pkg::Frames];
  logic mru_used [pftpr_pkg::Frames];

  pftpr_pkg::req_t pending_reqs[$];
  pftpr_pkg::res_t expected_results[$];
  int fail_count;
  int idle_cycles;
  int sent_count;
  int seen_count;
  int send_idle_pct;
  logic hold_sender;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Queue helpers: append at the back.
  task automatic add_expect(pftpr_pkg::res_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic add_req(pftpr_pkg::req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  function automatic int find_frame(logic [pftpr_pkg::PageBits-1:0] pg);
    for (int i = 0; i < pftpr_pkg::Frames; i++) begin
      if (tbl_valid[i] && tbl_page[i] == pg) return i;
    end
    return -1;
  endfunction

  // Move a frame to the front of the recency list.
  task automatic move_to_front(int f);
    int pos;
    pos = pftpr_pkg::Frames - 1;
    for (int i = 0; i < pftpr_pkg::Frames; i++) begin
      if (!mru_used[i] || int'(mru_list[i]) == f) begin
        pos = i;
        break;
      end
    end
    for (int i = pos; i > 0; i--) begin
      mru_list[i] = mru_list[i-1];
      mru_used[i] = mru_used[i-1];
    end
    mru_list[0] = f[pftpr_pkg::FrameBits-1:0];
    mru_used[0] = 1'b1;
  endtask

  // Lowest invalid frame, then the first unpinned hated one, then the last unpinned loved one.
  function automatic int choose_victim();
    int loved_pick;
    int f;
    loved_pick = -1;
    for (int i = 0; i < pftpr_pkg::Frames; i++) begin
      if (!tbl_valid[i]) return i;
    end
    for (int i = 0; i < pftpr_pkg::Frames; i++) begin
      if (!mru_used[i]) break;
      f = int'(mru_list[i]);
      if (tbl_pins[f] != 0) continue;
      if (!tbl_loved[f]) return f;
      loved_pick = f;
    end
    return loved_pick;
  endfunction

  function automatic pftpr_pkg::res_t mk_res(logic st, int fr, logic [1:0] act,
                                             logic [pftpr_pkg::PageBits-1:0] pg, logic lst);
    pftpr_pkg::res_t r;
    r.status = st;
    r.frame = fr[pftpr_pkg::FrameBits-1:0];
    r.action = act;
    r.io_page = pg;
    r.last = lst;
    return r;
  endfunction

  // Apply one request to the model and queue the results it causes.
  task automatic predict_request(pftpr_pkg::req_t rq);
    int f;
    f = find_frame(rq.page_id);
    case (rq.mode)
      pftpr_pkg::MODE_PIN: begin
        if (f >= 0) begin
          if (tbl_pins[f] == 8'd255) begin
            add_expect(mk_res(1'b1, f, pftpr_pkg::ACT_NONE, '0, 1'b1));
          end else begin
            tbl_pins[f]++;
            move_to_front(f);
            add_expect(mk_res(1'b0, f, pftpr_pkg::ACT_NONE, '0, 1'b1));
          end
        end else begin
          f = choose_victim();
          if (f < 0) begin
            add_expect(mk_res(1'b1, 0, pftpr_pkg::ACT_NONE, '0, 1'b1));
          end else begin
            if (tbl_valid[f] && tbl_dirty[f])
              add_expect(mk_res(1'b0, f, pftpr_pkg::ACT_WRITE, tbl_page[f], 1'b0));
            tbl_page[f] = rq.page_id;
            tbl_valid[f] = 1'b1;
            tbl_dirty[f] = 1'b0;
            tbl_pins[f] = 8'd1;
            move_to_front(f);
            if (rq.empty_page)
              add_expect(mk_res(1'b0, f, pftpr_pkg::ACT_NONE, '0, 1'b1));
            else
              add_expect(mk_res(1'b0, f, pftpr_pkg::ACT_READ, rq.page_id, 1'b1));
          end
        end
      end
      pftpr_pkg::MODE_UNPIN: begin
        if (f < 0) begin
          add_expect(mk_res(1'b1, 0, pftpr_pkg::ACT_NONE, '0, 1'b1));
        end else if (tbl_pins[f] == 8'd0) begin
          add_expect(mk_res(1'b1, f, pftpr_pkg::ACT_NONE, '0, 1'b1));
        end else begin
          tbl_pins[f]--;
          tbl_loved[f] = !rq.hate;
          if (rq.mark_dirty) tbl_dirty[f] = 1'b1;
          add_expect(mk_res(1'b0, f, pftpr_pkg::ACT_NONE, '0, 1'b1));
        end
      end
      pftpr_pkg::MODE_FREE: begin
        if (f < 0) begin
          add_expect(mk_res(1'b0, 0, pftpr_pkg::ACT_DEALL, rq.page_id, 1'b1));
        end else if (tbl_pins[f] != 8'd0) begin
          add_expect(mk_res(1'b1, f, pftpr_pkg::ACT_NONE, '0, 1'b1));
        end else begin
          tbl_valid[f] = 1'b0;
          tbl_dirty[f] = 1'b0;
          tbl_loved[f] = 1'b0;
          add_expect(mk_res(1'b0, f, pftpr_pkg::ACT_DEALL, rq.page_id, 1'b1));
        end
      end
      default: begin
        if (f < 0) begin
          add_expect(mk_res(1'b1, 0, pftpr_pkg::ACT_NONE, '0, 1'b1));
        end else begin
          tbl_dirty[f] = 1'b0;
          add_expect(mk_res(1'b0, f, pftpr_pkg::ACT_WRITE, rq.page_id, 1'b1));
        end
      end
    endcase
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic pftpr_pkg::req_t mk_req(logic [1:0] md,
                                             logic [pftpr_pkg::PageBits-1:0] pg,
                                             logic e, logic d, logic h);
    pftpr_pkg::req_t r;
    r.mode = md;
    r.page_id = pg;
    r.empty_page = e;
    r.mark_dirty = d;
    r.hate = h;
    return r;
  endfunction

  // Pages mostly come from a small pool so that hits, evictions and frees occur.
  function automatic logic [pftpr_pkg::PageBits-1:0] pick_page();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 17) return pftpr_pkg::PageBits'($urandom_range(0, 23));
    if (sel == 17)
      return {pftpr_pkg::PageBits{1'b1}} - pftpr_pkg::PageBits'($urandom_range(0, 2));
    return pftpr_pkg::PageBits'($urandom);
  endfunction

  function automatic pftpr_pkg::req_t random_req();
    int sel;
    logic [1:0] md;
    sel = $urandom_range(0, 99);
    if (sel < 45) md = pftpr_pkg::MODE_PIN;
    else if (sel < 80) md = pftpr_pkg::MODE_UNPIN;
    else if (sel < 90) md = pftpr_pkg::MODE_FREE;
    else md = pftpr_pkg::MODE_FLUSH;
    return mk_req(md, pick_page(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
  endfunction

  // Driver: offers the next pending request when the block is free, unless held or idling by send_idle_pct.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_req <= '0;
    end else if (start && !busy) begin
      predict_request(in_req);
      sent_count++;
      if (pending_reqs.size() > 0 && !hold_sender &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_req <= pending_reqs.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start && !hold_sender && pending_reqs.size() > 0 &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      in_req <= pending_reqs.pop_front();
      start <= 1'b1;
    end
  end

  // Monitor: compares each result with the oldest expectation.
  always @(posedge clk) begin
    pftpr_pkg::res_t want;
    if (rst_n && out_valid) begin
      seen_count++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_res));
      end else begin
        want = expected_results.pop_front();
        if (out_res.status !== want.status)
          report_mismatch($sformatf("status %b, want %b", out_res.status, want.status));
        if (out_res.frame !== want.frame)
          report_mismatch($sformatf("frame %0d, want %0d", out_res.frame, want.frame));
        if (out_res.action !== want.action)
          report_mismatch($sformatf("action %0d, want %0d", out_res.action, want.action));
        if (out_res.io_page !== want.io_page)
          report_mismatch($sformatf("io_page %h, want %h", out_res.io_page, want.io_page));
        if (out_res.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_res.last, want.last));
      end
    end
  end

  // Watchdog: ends the run when nothing is accepted and no result comes for too long.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    send_idle_pct = 0;
    hold_sender = 1'b0;
    for (int i = 0; i < pftpr_pkg::Frames; i++) begin
      tbl_page[i] = '0;
      tbl_valid[i] = 1'b0;
      tbl_dirty[i] = 1'b0;
      tbl_loved[i] = 1'b0;
      tbl_pins[i] = '0;
      mru_list[i] = '0;
      mru_used[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: failures on an empty table, extreme pages, every mode,
    // dirty write-back on eviction, loved and hated victims.
    add_req(mk_req(pftpr_pkg::MODE_UNPIN, 24'h000005, 1'b0, 1'b0, 1'b0));
    add_req(mk_req(pftpr_pkg::MODE_FLUSH, 24'h000005, 1'b0, 1'b0, 1'b0));
    add_req(mk_req(pftpr_pkg::MODE_FREE, 24'hFFFFFF, 1'b0, 1'b0, 1'b0));
    add_req(mk_req(pftpr_pkg::MODE_PIN, 24'hFFFFFF, 1'b0, 1'b0, 1'b0));
    add_req(mk_req(pftpr_pkg::MODE_PIN, 24'h000000, 1'b1, 1'b0, 1'b0));
    add_req(mk_req(pftpr_pkg::MODE_PIN, 24'hFFFFFF, 1'b1, 1'b1, 1'b1));
    add_req(mk_req(pftpr_pkg::MODE_FREE, 24'hFFFFFF, 1'b0, 1'b0, 1'b0));
    add_req(mk_req(pftpr_pkg::MODE_UNPIN, 24'hFFFFFF, 1'b0, 1'b1, 1'b1));
    add_req(mk_req(pftpr_pkg::MODE_UNPIN, 24'hFFFFFF, 1'b0, 1'b1, 1'b0));
    add_req(mk_req(pftpr_pkg::MODE_UNPIN, 24'hFFFFFF, 1'b0, 1'b0, 1'b0));
    add_req(mk_req(pftpr_pkg::MODE_FLUSH, 24'hFFFFFF, 1'b0, 1'b0, 1'b0));
    add_req(mk_req(pftpr_pkg::MODE_UNPIN, 24'h000000, 1'b1, 1'b1, 1'b1));
    add_req(mk_req(pftpr_pkg::MODE_FREE, 24'h000000, 1'b1, 1'b1, 1'b1));
    for (int i = 1; i <= 12; i++)
      add_req(mk_req(pftpr_pkg::MODE_PIN, pftpr_pkg::PageBits'(i * 24'h111111), i[0],
                     1'b0, 1'b0));
    wait_drained();

    // Fill the table, then make frames unpinned and dirty so misses evict.
    for (int i = 0; i < 16; i++)
      add_req(mk_req(pftpr_pkg::MODE_PIN, pftpr_pkg::PageBits'(32 + i), 1'b1, 1'b0, 1'b0));
    for (int i = 0; i < 16; i++)
      add_req(mk_req(pftpr_pkg::MODE_UNPIN, pftpr_pkg::PageBits'(32 + i), 1'b0, 1'b1, i[0]));
    for (int i = 0; i < 8; i++)
      add_req(mk_req(pftpr_pkg::MODE_PIN, pftpr_pkg::PageBits'(64 + i), 1'b0, 1'b0, 1'b0));
    wait_drained();

    // Request pins of one page more times than the pin count can hold, then unpin it.
    add_req(mk_req(pftpr_pkg::MODE_PIN, 24'h0000AA, 1'b0, 1'b0, 1'b0));
    for (int i = 0; i < 256; i++)
      add_req(mk_req(pftpr_pkg::MODE_PIN, 24'h0000AA, 1'b1, 1'b0, 1'b0));
    for (int i = 0; i < 255; i++)
      add_req(mk_req(pftpr_pkg::MODE_UNPIN, 24'h0000AA, 1'b0, i[3], i[0]));

    // Random phases with different sender idling.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: send_idle_pct = 0;
        1: send_idle_pct = 82;
        2: send_idle_pct = 7;
        default: send_idle_pct = 0;
      endcase
      for (int i = 0; i < 331; i++) add_req(random_req());
      while (pending_reqs.size() > 0) @(posedge clk);
      // Hold off until every expected result has come.
      hold_sender = 1'b1;
      wait_drained();
      hold_sender = 1'b0;
    end

    wait_drained();
    repeat (80) @(posedge clk);
    $display("covered %0d requests and %0d results over four idling phases", sent_count,
             seen_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
